// ----- rtl/kreyvium_keystream_masked_adder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Kreyvium masked keystream core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KREYVIUM_KEYSTREAM_MASKED_ADDER_CORE_DEFINES_SVH
`define KREYVIUM_KEYSTREAM_MASKED_ADDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KVMA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define KVMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KVMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KVMA_ASSERT(lbl, cond)
`define KVMA_ASSERT_IMP(lbl, ante, cons)
`define KVMA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/kvma_pkg.sv -----
// ----------------------------------------------------------------------------
// Kreyvium masked keystream package
// Shared widths, types, codes, the key load and the 64-round state update function.
// ----------------------------------------------------------------------------
package kvma_pkg;

  localparam int KVMA_STATE_BITS    = 288;
  localparam int KVMA_KEY_RING_BITS = 128;
  localparam int KVMA_IV_RING_BITS  = 128;
  localparam int KVMA_USED_KEY_BITS = 64;
  localparam int KVMA_WORD_BITS     = 64;
  localparam int KVMA_WARM_STEPS    = (4 * KVMA_STATE_BITS) / KVMA_WORD_BITS;
  localparam int KVMA_WARM_CNT_W    = $clog2(KVMA_WARM_STEPS);
  localparam int KVMA_QUEUE_DEPTH   = 2;
  localparam int KVMA_CFG_IDX_W     = 1;

  localparam logic [KVMA_IV_RING_BITS-1:0] KVMA_IV_RING_INIT = {32{4'h1}};
  localparam logic [KVMA_IV_RING_BITS-1:0] KVMA_STATE_IV     = {32{4'h8}};

  typedef enum logic [KVMA_CFG_IDX_W-1:0] {
    KVMA_REG_CLIENT = 1'b0,
    KVMA_REG_SERVER = 1'b1
  } kvma_reg_t;

  typedef enum logic [1:0] {
    KVMA_READY,
    KVMA_WARM,
    KVMA_FINISH
  } kvma_state_t;

  typedef struct packed {
    logic [KVMA_WORD_BITS-1:0] mask_word;
    logic                      restart;
  } kvma_item_t;

  typedef struct packed {
    logic [KVMA_STATE_BITS-1:0]    s;
    logic [KVMA_KEY_RING_BITS-1:0] k;
    logic [KVMA_IV_RING_BITS-1:0]  v;
  } kvma_regs_t;

  typedef struct packed {
    kvma_regs_t                regs;
    logic [KVMA_WORD_BITS-1:0] z;
  } kvma_step_t;

  function automatic kvma_regs_t kvma_load(input logic [KVMA_USED_KEY_BITS-1:0] key);
    kvma_regs_t r;
    r   = '0;
    r.s[KVMA_USED_KEY_BITS-1:0] = key;
    r.s[220:93]  = KVMA_STATE_IV;
    r.s[286:221] = '1;
    for (int m = 0; m < KVMA_USED_KEY_BITS; m++) begin
      r.k[KVMA_KEY_RING_BITS-KVMA_USED_KEY_BITS+m] = key[KVMA_USED_KEY_BITS-1-m];
    end
    r.v = KVMA_IV_RING_INIT;
    return r;
  endfunction

  // Every tap sits at least 65 positions from an insertion point, so all
  // 64 rounds read the current state directly and each lane is independent.
  function automatic kvma_step_t kvma_advance(input kvma_regs_t r);
    kvma_step_t                n;
    logic [KVMA_WORD_BITS-1:0] kb;
    logic [KVMA_WORD_BITS-1:0] vb;
    logic [KVMA_WORD_BITS-1:0] a;
    logic [KVMA_WORD_BITS-1:0] b;
    logic [KVMA_WORD_BITS-1:0] c;
    n.regs.s = r.s << KVMA_WORD_BITS;
    for (int t = 0; t < KVMA_WORD_BITS; t++) begin
      kb[t] = r.k[KVMA_KEY_RING_BITS-1-t];
      vb[t] = r.v[KVMA_IV_RING_BITS-1-t];
      a[t]  = r.s[65-t] ^ r.s[92-t];
      b[t]  = r.s[161-t] ^ r.s[176-t];
      c[t]  = r.s[242-t] ^ r.s[287-t] ^ kb[t];
      n.z[t] = a[t] ^ b[t] ^ c[t];
      n.regs.s[63-t]  = c[t] ^ (r.s[285-t] & r.s[286-t]) ^ r.s[68-t];
      n.regs.s[156-t] = a[t] ^ (r.s[90-t] & r.s[91-t]) ^ r.s[170-t] ^ vb[t];
      n.regs.s[240-t] = b[t] ^ (r.s[174-t] & r.s[175-t]) ^ r.s[263-t];
    end
    n.regs.k = {r.k[KVMA_WORD_BITS-1:0], r.k[KVMA_KEY_RING_BITS-1:KVMA_WORD_BITS]};
    n.regs.v = {r.v[KVMA_WORD_BITS-1:0], r.v[KVMA_IV_RING_BITS-1:KVMA_WORD_BITS]};
    return n;
  endfunction

endpackage

// ----- rtl/kvma_front.sv -----
// ----------------------------------------------------------------------------
// Kreyvium masked keystream input queue
// Accepts items, splits mask and restart flag, and holds them for the engine.
// ----------------------------------------------------------------------------
`include "kreyvium_keystream_masked_adder_core_defines.svh"

module kvma_front #(
  parameter int DEPTH = kvma_pkg::KVMA_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kvma_pkg::KVMA_WORD_BITS-1:0] in_tdata,
  input  logic                                in_tuser,
  output logic                                q_valid,
  output kvma_pkg::kvma_item_t                q_item,
  input  logic                                q_pop
);
  import kvma_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  kvma_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  kvma_item_t       in_item;

  assign in_tready         = (cnt_r != FULL_CNT);
  assign push              = in_tvalid && in_tready;
  assign q_valid           = (cnt_r != '0);
  assign q_item            = mem_r[rd_ptr_r];
  assign in_item.mask_word = in_tdata;
  assign in_item.restart   = in_tuser;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  `KVMA_ASSERT(a_cnt_bound, cnt_r <= FULL_CNT)
  `KVMA_ASSERT_IMP(a_pop_nonempty, q_pop, cnt_r != '0)
  `KVMA_ASSERT_NXT(a_cnt_up, push && !q_pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ----- rtl/kvma_engine.sv -----
// ----------------------------------------------------------------------------
// Kreyvium masked keystream engine
// Loads and warms the cipher state, takes 64 keystream bits per item and
// adds the mask into a registered output stage.
// ----------------------------------------------------------------------------
`include "kreyvium_keystream_masked_adder_core_defines.svh"

module kvma_engine (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [kvma_pkg::KVMA_USED_KEY_BITS-1:0] key,
  input  logic                                    q_valid,
  input  kvma_pkg::kvma_item_t                    q_item,
  output logic                                    q_pop,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [kvma_pkg::KVMA_WORD_BITS-1:0]     out_tdata
);
  import kvma_pkg::*;

  localparam logic [KVMA_WARM_CNT_W-1:0] WARM_LAST = KVMA_WARM_CNT_W'(KVMA_WARM_STEPS - 1);

  kvma_state_t               state_r, state_nxt;
  kvma_regs_t                regs_r, regs_nxt;
  logic [KVMA_WARM_CNT_W-1:0] warm_cnt_r, warm_cnt_nxt;
  logic [KVMA_WORD_BITS-1:0] mask_r, mask_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [KVMA_WORD_BITS-1:0] out_data_r, out_data_nxt;
  logic                      slot_free;
  kvma_step_t                adv;

  assign adv        = kvma_advance(regs_r);
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    regs_nxt      = regs_r;
    warm_cnt_nxt  = warm_cnt_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    case (state_r)
      KVMA_READY: begin
        if (q_valid) begin
          if (q_item.restart) begin
            regs_nxt     = kvma_load(key);
            mask_nxt     = q_item.mask_word;
            warm_cnt_nxt = '0;
            q_pop        = 1'b1;
            state_nxt    = KVMA_WARM;
          end else if (slot_free) begin
            regs_nxt      = adv.regs;
            out_valid_nxt = 1'b1;
            out_data_nxt  = adv.z + q_item.mask_word;
            q_pop         = 1'b1;
          end
        end
      end
      KVMA_WARM: begin
        regs_nxt     = adv.regs;
        warm_cnt_nxt = warm_cnt_r + 1'b1;
        if (warm_cnt_r == WARM_LAST) begin
          state_nxt = KVMA_FINISH;
        end
      end
      KVMA_FINISH: begin
        if (slot_free) begin
          regs_nxt      = adv.regs;
          out_valid_nxt = 1'b1;
          out_data_nxt  = adv.z + mask_r;
          state_nxt     = KVMA_READY;
        end
      end
      default: begin
        state_nxt = KVMA_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= KVMA_READY;
      regs_r      <= '0;
      warm_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      regs_r      <= regs_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  `KVMA_ASSERT_IMP(a_pop_ready, q_pop, state_r == KVMA_READY)
  `KVMA_ASSERT_IMP(a_warm_bound, state_r == KVMA_WARM, warm_cnt_r <= WARM_LAST)
  `KVMA_ASSERT_NXT(a_finish_out, state_r == KVMA_FINISH && state_nxt == KVMA_READY,
                   out_valid_r)

endmodule

// ----- rtl/kreyvium_keystream_masked_adder_core.sv -----
// ----------------------------------------------------------------------------
// Kreyvium masked keystream core
// Kreyvium keystream generator on a 64-bit shared key with a masked output.
// ----------------------------------------------------------------------------
// Input items arrive on in_* (mask in in_tdata, restart flag in in_tuser) and
// each produces one masked word on out_*. The key shares are written through
// cfg_we / cfg_index / cfg_wdata and take effect at the next restart item.
// For an item without restart, the 288-bit state advances 64 rounds at once
// and the keystream word is added to the mask into the output register.
// out_tvalid rises once the item has passed the input queue and the output
// register, and the sustained rate is one item per cycle while out_tready
// stays high and no restart item comes. A restart item first loads the
// state from the key, then warms it up over 4 x 288 rounds in 64-round
// steps, then emits its word, all through the single 64-round update unit.
// A two-entry input queue keeps accepting until full while the engine warms up
// or the output waits. When out_tready is low the result holds in the output
// register and the engine stops once it has a new word to place.
// Reset clears the queue, the key shares and the cipher state to zeros.
// ----------------------------------------------------------------------------
module kreyvium_keystream_masked_adder_core #(
  parameter int QUEUE_DEPTH = kvma_pkg::KVMA_QUEUE_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [kvma_pkg::KVMA_WORD_BITS-1:0]     in_tdata,   // [63:0] mask_word
  input  logic                                    in_tuser,   // [0] restart
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [kvma_pkg::KVMA_WORD_BITS-1:0]     out_tdata,  // [63:0] masked_word
  input  logic                                    cfg_we,
  input  logic [kvma_pkg::KVMA_CFG_IDX_W-1:0]     cfg_index,
  input  logic [kvma_pkg::KVMA_USED_KEY_BITS-1:0] cfg_wdata
);
  import kvma_pkg::*;

  logic [KVMA_USED_KEY_BITS-1:0] share_client_r, share_client_nxt;
  logic [KVMA_USED_KEY_BITS-1:0] share_server_r, share_server_nxt;
  logic [KVMA_USED_KEY_BITS-1:0] key;
  logic                          q_valid;
  kvma_item_t                    q_item;
  logic                          q_pop;

  assign key = share_client_r ^ share_server_r;

  always_comb begin
    share_client_nxt = share_client_r;
    share_server_nxt = share_server_r;
    if (cfg_we) begin
      case (kvma_reg_t'(cfg_index))
        KVMA_REG_CLIENT: share_client_nxt = cfg_wdata;
        KVMA_REG_SERVER: share_server_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_client_r <= '0;
      share_server_r <= '0;
    end else begin
      share_client_r <= share_client_nxt;
      share_server_r <= share_server_nxt;
    end
  end

  kvma_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  kvma_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        (key),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Kreyvium masked keystream core
// Drives mask words with and without restart through the input stream and
// rewrites the key shares between phases. Each output word is compared with
// a bit-serial Kreyvium model in the bench, or a typed row's result. A directed
// table comes first, then random phases. Both stream sides idle at random,
// and one long output hold-off fills the core until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import kvma_pkg::*;

  localparam int WORD_W          = KVMA_WORD_BITS;
  localparam int WARMUP_ROUNDS   = 4 * KVMA_STATE_BITS;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 172;
  localparam int DIRECTED_ROWS   = 22;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int REPORT_LIMIT    = 10;

  typedef enum logic {
    ROW_ITEM,
    ROW_KEY_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    kvma_reg_t         share;
    logic [WORD_W-1:0] word;
    logic              restart;
    logic              typed;
    logic [WORD_W-1:0] result;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [WORD_W-1:0]                 in_tdata = '0;
  logic                              in_tuser = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [WORD_W-1:0]                 out_tdata;
  logic                              cfg_we = 1'b0;
  logic [KVMA_CFG_IDX_W-1:0]         cfg_index = '0;
  logic [KVMA_USED_KEY_BITS-1:0]     cfg_wdata = '0;

  logic [KVMA_STATE_BITS-1:0]        ks_state = '0;
  logic [KVMA_KEY_RING_BITS-1:0]     ks_key_ring = '0;
  logic [KVMA_IV_RING_BITS-1:0]      ks_iv_ring = '0;
  logic [KVMA_USED_KEY_BITS-1:0]     client_share = '0;
  logic [KVMA_USED_KEY_BITS-1:0]     server_share = '0;

  logic [WORD_W-1:0]                 pending_masked_words[$];
  plan_row_t                         directed_plan[DIRECTED_ROWS];

  int  sender_gap_odds = 0;
  int  receiver_stall_odds = 0;
  bit  hold_off_pending = 1'b0;
  int  quiet_cycles = 0;
  int  mismatch_count = 0;
  int  items_sent = 0;
  int  restarts_sent = 0;
  int  words_checked = 0;
  int  key_writes = 0;
  int  input_stall_cycles = 0;

  kreyvium_keystream_masked_adder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic kreyvium_round();
    logic kb;
    logic vb;
    logic a;
    logic b;
    logic c;
    logic z;
    kb = ks_key_ring[KVMA_KEY_RING_BITS-1];
    vb = ks_iv_ring[KVMA_IV_RING_BITS-1];
    a  = ks_state[65] ^ ks_state[92];
    b  = ks_state[161] ^ ks_state[176];
    c  = ks_state[242] ^ ks_state[287] ^ kb;
    z  = a ^ b ^ c;
    a  = a ^ (ks_state[90] & ks_state[91]) ^ ks_state[170] ^ vb;
    b  = b ^ (ks_state[174] & ks_state[175]) ^ ks_state[263];
    c  = c ^ (ks_state[285] & ks_state[286]) ^ ks_state[68];
    ks_state      = {ks_state[KVMA_STATE_BITS-2:0], c};
    ks_state[93]  = a;
    ks_state[177] = b;
    ks_key_ring   = {ks_key_ring[KVMA_KEY_RING_BITS-2:0], kb};
    ks_iv_ring    = {ks_iv_ring[KVMA_IV_RING_BITS-2:0], vb};
    return z;
  endfunction

  function automatic void kreyvium_reload();
    logic [KVMA_USED_KEY_BITS-1:0] key;
    key         = client_share ^ server_share;
    ks_state    = '0;
    ks_key_ring = '0;
    ks_iv_ring  = '0;
    ks_state[KVMA_USED_KEY_BITS-1:0] = key;
    for (int j = 0; j < KVMA_IV_RING_BITS; j++) begin
      ks_state[93+j] = (j % 4 == 3);
      ks_iv_ring[j]  = (j % 4 == 0);
    end
    ks_state[KVMA_STATE_BITS-2:93+KVMA_IV_RING_BITS] = '1;
    for (int m = 0; m < KVMA_USED_KEY_BITS; m++) begin
      ks_key_ring[KVMA_KEY_RING_BITS-KVMA_USED_KEY_BITS+m] = key[KVMA_USED_KEY_BITS-1-m];
    end
    repeat (WARMUP_ROUNDS) void'(kreyvium_round());
  endfunction

  function automatic logic [WORD_W-1:0] masked_keystream(input logic [WORD_W-1:0] mask,
                                                         input logic restart);
    logic [WORD_W-1:0] word;
    word = '0;
    if (restart) begin
      kreyvium_reload();
    end
    for (int k = 0; k < WORD_W; k++) begin
      word[k] = kreyvium_round();
    end
    return word + mask;
  endfunction

  function automatic logic [KVMA_USED_KEY_BITS-1:0] random_share();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_mask(input logic [WORD_W-1:0] mask, input logic restart,
                           input logic typed, input logic [WORD_W-1:0] typed_word);
    logic [WORD_W-1:0] predicted;
    if (sender_gap_odds != 0 && $urandom_range(0, sender_gap_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mask;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    predicted = masked_keystream(mask, restart);
    pending_masked_words = {pending_masked_words, (typed ? typed_word : predicted)};
    items_sent++;
    if (restart) begin
      restarts_sent++;
    end
  endtask

  task automatic write_key_share(input kvma_reg_t share,
                                 input logic [KVMA_USED_KEY_BITS-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_masked_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= share;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (share == KVMA_REG_CLIENT) begin
      client_share = value;
    end else begin
      server_share = value;
    end
    key_writes++;
  endtask

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] expected_word,
                               input logic [WORD_W-1:0] actual_word);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected %h, got %h", $time, what, expected_word, actual_word);
    end
  endtask

  always @(posedge clk) begin
    logic [WORD_W-1:0] expected_word;
    if (rst_n) begin
      if (in_tvalid && !in_tready) begin
        input_stall_cycles++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_masked_words.size() == 0) begin
          note_mismatch("unexpected masked_word transfer", '0, out_tdata);
        end else begin
          expected_word = pending_masked_words.pop_front();
          if (out_tdata !== expected_word) begin
            note_mismatch($sformatf("masked_word of word %0d", words_checked),
                          expected_word, out_tdata);
          end
          words_checked++;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        out_tready <= 1'b0;
        for (hold = 0; hold < HOLD_OFF_CYCLES; hold++) @(posedge clk);
        hold_off_pending = 1'b0;
        out_tready <= 1'b1;
      end else if (receiver_stall_odds != 0 &&
                   $urandom_range(0, receiver_stall_odds - 1) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] mask;
    logic              restart_bit;
    bit                last_phase;
    directed_plan = '{
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b0, 1'b1, 64'h0000000000000000},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'hffffffffffffffff, 1'b0, 1'b1, 64'hffffffffffffffff},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h8000000000000001, 1'b0, 1'b1, 64'h8000000000000001},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h5555555555555555, 1'b0, 1'b1, 64'h5555555555555555},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b1, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'hffffffffffffffff, 1'b0, 1'b0, 64'h0},
      '{ROW_KEY_WRITE, KVMA_REG_CLIENT, 64'hffffffffffffffff, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0123456789abcdef, 1'b1, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'hffffffffffffffff, 1'b0, 1'b0, 64'h0},
      '{ROW_KEY_WRITE, KVMA_REG_SERVER, 64'hffffffffffffffff, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b1, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000001, 1'b1, 1'b0, 64'h0},
      '{ROW_KEY_WRITE, KVMA_REG_CLIENT, 64'h0123456789abcdef, 1'b0, 1'b0, 64'h0},
      '{ROW_KEY_WRITE, KVMA_REG_SERVER, 64'h0000000000000000, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'hffffffffffffffff, 1'b1, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000000, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h0000000000000001, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'hfffffffffffffffe, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h8000000000000000, 1'b0, 1'b0, 64'h0},
      '{ROW_ITEM,      KVMA_REG_CLIENT, 64'h7fffffffffffffff, 1'b0, 1'b0, 64'h0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_gap_odds     = 4;
    receiver_stall_odds = 4;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_KEY_WRITE) begin
        write_key_share(directed_plan[i].share, directed_plan[i].word);
      end else begin
        send_mask(directed_plan[i].word, directed_plan[i].restart,
                  directed_plan[i].typed, directed_plan[i].result);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      last_phase = (phase == RANDOM_PHASES - 1);
      write_key_share(KVMA_REG_CLIENT, random_share());
      write_key_share(KVMA_REG_SERVER, random_share());
      sender_gap_odds     = last_phase ? 0 : 2 + 3 * $urandom_range(0, 2);
      receiver_stall_odds = last_phase ? 0 : 2 + 3 * $urandom_range(0, 2);
      if (phase == 2) begin
        hold_off_pending = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mask = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) begin
          mask = $urandom_range(0, 1) ? '1 : '0;
        end
        restart_bit = (n == 0 && phase != 3) || ($urandom_range(0, 19) == 0);
        send_mask(mask, restart_bit, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_masked_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d mask words (%0d with restart) over %0d key share writes.",
             items_sent, restarts_sent, key_writes);
    $display("Checked %0d output words; input was back-pressured for %0d cycles; %0d mismatches.",
             words_checked, input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
